/* rtl/bfd_pkg.sv */
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types and constants for the black frame detector.
// ----------------------------------------------------------------------------
package bfd_pkg;

  localparam int unsigned PCT_FULL     = 100;
  localparam int unsigned DIV_STEPS    = 8;
  localparam int unsigned STEP_W       = $clog2(DIV_STEPS);

  localparam logic [6:0]  AMOUNT_RST   = 7'd98;
  localparam logic [8:0]  THRESH_RST   = 9'h020;
  localparam logic [12:0] WIDTH_RST    = 13'd720;
  localparam logic [12:0] HEIGHT_RST   = 13'd576;

  typedef enum logic [1:0] {
    REG_BLACK_AMOUNT    = 2'd0,
    REG_BLACK_THRESHOLD = 2'd1,
    REG_FRAME_WIDTH     = 2'd2,
    REG_FRAME_HEIGHT    = 2'd3
  } bfd_reg_t;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_I       = 2'd1,
    KIND_P       = 2'd2,
    KIND_B       = 2'd3
  } bfd_kind_t;

  typedef struct packed {
    logic accept;
    logic mul_load;
    logic div_step;
    logic check;
    logic emit;
  } bfd_cmd_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
    logic failed;
    logic out_full;
  } bfd_sts_t;

endpackage

/* rtl/bfd_ctrl.sv */
// ----------------------------------------------------------------------------
// bfd_ctrl
// Sequencer for the detector: pixel intake, row check division and report.
// ----------------------------------------------------------------------------
module bfd_ctrl
  import bfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     cfg_ready,
  input  bfd_sts_t sts,
  output bfd_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_DIV   = 5'b00100,
    S_CHECK = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              pend_r, pend_nxt;
  logic              accept;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign accept    = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.accept = accept;
        if (accept && sts.row_end && !sts.failed) begin
          state_nxt = S_MUL;
          pend_nxt  = sts.frame_end;
        end else if (accept && sts.frame_end) begin
          state_nxt = S_EMIT;
        end
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = pend_r ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!sts.out_full) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      pend_r  <= pend_nxt;
    end
  end

  a_mul_then_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |=> (state_r == S_DIV && step_r == '0))
    else $error("division did not start after the multiply");

  a_div_then_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && step_r == STEP_LAST) |=> (state_r == S_CHECK))
    else $error("row check did not follow the last division step");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_full)
    else $error("report loaded while the output register was still held");

endmodule

/* rtl/bfd_datapath.sv */
// ----------------------------------------------------------------------------
// bfd_datapath
// Configuration registers, pixel counters, restoring divider and output
// register of the detector.
// ----------------------------------------------------------------------------
module bfd_datapath
  import bfd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic [7:0]  in_luma,
  input  logic [2:0]  in_picture_type,
  input  bfd_cmd_t    cmd,
  output bfd_sts_t    sts,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_black,
  output logic [6:0]  out_black_percent,
  output logic [31:0] out_frame_number,
  output logic [31:0] out_last_key_number,
  output logic [1:0]  out_frame_kind
);

  localparam int unsigned WID_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HGT_W = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
  localparam int unsigned CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned NUM_W = CNT_W + 7;

  logic [6:0]  amount_r;
  logic [8:0]  thresh_r;
  logic [12:0] width_cfg_r;
  logic [12:0] height_cfg_r;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic             failed_r;
  logic [6:0]       failed_pct_r;
  logic [6:0]       last_pct_r;
  logic [31:0]      frame_cnt_r;
  logic [31:0]      last_key_r;
  logic [1:0]       kind_r;

  logic [NUM_W-1:0] num_r;
  logic [WID_W-1:0] wid_r;
  logic [HGT_W-1:0] rows_r;
  logic [NUM_W-1:0] rem_r;
  logic [NUM_W-1:0] dsh_r;
  logic [7:0]       quo_r;
  logic             out_valid_r;

  logic [WID_W-1:0]       wid_c;
  logic [HGT_W-1:0]       hgt_c;
  logic [6:0]             amount_c;
  logic [WID_W+HGT_W-1:0] prod;
  logic [6:0]             pct;
  logic [1:0]             kind_c;
  logic                   dark;

  always_comb begin
    if (width_cfg_r == '0) begin
      wid_c = WID_W'(1);
    end else if (32'(width_cfg_r) > MAX_WIDTH) begin
      wid_c = WID_W'(MAX_WIDTH);
    end else begin
      wid_c = WID_W'(width_cfg_r);
    end
    if (height_cfg_r == '0) begin
      hgt_c = HGT_W'(1);
    end else if (32'(height_cfg_r) > MAX_HEIGHT) begin
      hgt_c = HGT_W'(MAX_HEIGHT);
    end else begin
      hgt_c = HGT_W'(height_cfg_r);
    end
  end

  assign amount_c  = (32'(amount_r) > PCT_FULL) ? 7'(PCT_FULL) : amount_r;
  assign dark      = ({1'b0, in_luma} < thresh_r);
  assign cnt_nxt   = cnt_r + CNT_W'(dark);
  assign kind_c    = in_picture_type[2] ? KIND_UNKNOWN : in_picture_type[1:0];
  assign prod      = wid_r * rows_r;

  assign sts.row_end   = (32'(col_r) + 32'd1 >= 32'(wid_c));
  assign sts.frame_end = sts.row_end && (32'(row_r) + 32'd1 >= 32'(hgt_c));
  assign sts.failed    = failed_r;
  assign sts.out_full  = out_valid_r && out_stall;

  always_comb begin
    if (quo_r[7] || (32'(quo_r[6:0]) > PCT_FULL)) begin
      pct = 7'(PCT_FULL);
    end else begin
      pct = quo_r[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amount_r     <= AMOUNT_RST;
      thresh_r     <= THRESH_RST;
      width_cfg_r  <= WIDTH_RST;
      height_cfg_r <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLACK_AMOUNT:    amount_r     <= cfg_data[6:0];
        REG_BLACK_THRESHOLD: thresh_r     <= cfg_data[8:0];
        REG_FRAME_WIDTH:     width_cfg_r  <= cfg_data;
        REG_FRAME_HEIGHT:    height_cfg_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      col_r        <= '0;
      row_r        <= '0;
      failed_r     <= 1'b0;
      failed_pct_r <= '0;
      last_pct_r   <= '0;
      frame_cnt_r  <= '0;
      last_key_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !cmd.emit) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.accept) begin
        cnt_r <= cnt_nxt;
        if (sts.row_end) begin
          col_r <= '0;
          if (!sts.frame_end) begin
            row_r <= row_r + 1'b1;
          end else if (kind_c == KIND_I) begin
            last_key_r <= frame_cnt_r;
          end
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      if (cmd.check) begin
        last_pct_r <= pct;
        if (pct < amount_c) begin
          failed_r     <= 1'b1;
          failed_pct_r <= pct;
        end
      end
      if (cmd.emit) begin
        out_valid_r  <= 1'b1;
        frame_cnt_r  <= frame_cnt_r + 1'b1;
        cnt_r        <= '0;
        row_r        <= '0;
        failed_r     <= 1'b0;
        failed_pct_r <= '0;
        last_pct_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      num_r  <= NUM_W'(cnt_nxt) * NUM_W'(PCT_FULL);
      wid_r  <= wid_c;
      rows_r <= HGT_W'(32'(row_r) + 32'd1);
      kind_r <= kind_c;
    end
    if (cmd.mul_load) begin
      rem_r <= num_r;
      dsh_r <= NUM_W'({prod, 7'd0});
      quo_r <= '0;
    end else if (cmd.div_step) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        quo_r <= {quo_r[6:0], 1'b1};
      end else begin
        quo_r <= {quo_r[6:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
    if (cmd.emit) begin
      out_is_black        <= !failed_r;
      out_black_percent   <= failed_r ? failed_pct_r : last_pct_r;
      out_frame_number    <= frame_cnt_r;
      out_last_key_number <= last_key_r;
      out_frame_kind      <= kind_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/black_frame_detector_unit.sv */
// ----------------------------------------------------------------------------
// black_frame_detector_unit
// Counts dark luma pixels of a raster frame and reports whether it is black.
// ----------------------------------------------------------------------------
// The unit takes one pixel per clock inside a row. At the end of a row, while
// the frame has not yet failed, the input stalls while the unit forms width
// times rows, runs the restoring divider that produces one quotient bit per
// cycle, and compares the percentage with the required amount. The last pixel
// of a frame also stalls the input until the report is loaded, longer if the
// previous report is still held by the output side. Configuration writes are
// taken only while no pixel is in work.
module black_frame_detector_unit
  import bfd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_luma,
  input  logic [2:0]  in_picture_type,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_black,
  output logic [6:0]  out_black_percent,
  output logic [31:0] out_frame_number,
  output logic [31:0] out_last_key_number,
  output logic [1:0]  out_frame_kind
);

  bfd_cmd_t cmd;
  bfd_sts_t sts;

  bfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfd_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_luma             (in_luma),
    .in_picture_type     (in_picture_type),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_is_black        (out_is_black),
    .out_black_percent   (out_black_percent),
    .out_frame_number    (out_frame_number),
    .out_last_key_number (out_last_key_number),
    .out_frame_kind      (out_frame_kind)
  );

endmodule
